// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL of the controller.
// Depends on nothing; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent true implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
// Antecedent true implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/pvc_pkg.sv -----
// Package of the position/velocity controller: widths, register codes,
// config struct and the 32-bit saturation helper. Depends on nothing.
package pvc_pkg;

  localparam int IDX_W    = 3;
  localparam int REG_W    = 31;
  localparam int DATA_W   = 32;
  localparam int MUL_A_W  = 33;
  localparam int MUL_B_W  = 32;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = 52;

  localparam logic [IDX_W-1:0] REG_GAIN_P        = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_I        = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_D        = 3'd2;
  localparam logic [IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd3;
  localparam logic [IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd4;
  localparam logic [IDX_W-1:0] REG_ANGULAR_MODE  = 3'd5;
  localparam logic [IDX_W-1:0] REG_CLAMP_ENABLE  = 3'd6;

  localparam logic [REG_W-1:0] SAMPLE_PERIOD_RST = 31'd655;
  localparam logic [REG_W-1:0] DRIVE_LIMIT_RST   = 31'h7fff_ffff;

  // pi and 2*pi in Q16.16, sized to the wrap datapath
  localparam logic signed [33:0] Q_PI     = 34'sd205887;
  localparam logic signed [33:0] Q_TWO_PI = 34'sd411775;

  // Operand pairs of the shared multiplier, one per sequencer step.
  typedef enum logic [1:0] {
    OP_TRAP, OP_GAIN_P, OP_GAIN_I, OP_GAIN_D
  } mul_op_t;

  typedef struct packed {
    logic [REG_W-1:0] gain_p;
    logic [REG_W-1:0] gain_i;
    logic [REG_W-1:0] gain_d;
    logic [REG_W-1:0] sample_period;
    logic [REG_W-1:0] drive_limit;
    logic             angular_mode;
    logic             clamp_enable;
  } cfg_t;

  // True when a wide value fits in 32 bits signed.
  function automatic logic fits32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-32:0] upper;
    upper = v[ACC_W-1:31];
    return (&upper) || (~|upper);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (fits32(v)) begin
      r = v[31:0];
    end else if (v[ACC_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

// ----- design/pvc_if.sv -----
// Valid/ready channels of the controller: sample words in, drive words out.
// Depends on nothing.
interface pvc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] ref_position;
  logic signed [31:0] ref_velocity;
  logic signed [31:0] meas_position;
  logic signed [31:0] meas_velocity;

  modport source (output valid, ref_position, ref_velocity, meas_position,
                  meas_velocity, input ready);
  modport sink   (input valid, ref_position, ref_velocity, meas_position,
                  meas_velocity, output ready);
endinterface

interface pvc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic               held;

  modport source (output valid, drive, held, input ready);
  modport sink   (input valid, drive, held, output ready);
endinterface

// ----- design/pid_position_velocity_controller.sv -----
// Top level of the position/velocity PID controller: sequencer, state and
// output register. Depends on pvc_pkg, pvc_if, pvc_cfg, pvc_opsel, pvc_mul, assert_macros.
//
// Usage:
//   sample  : sink channel; one word carries both references and both
//             measurements (signed Q16.16). Accepted when valid and ready.
//   result  : source channel; one word per sample with the drive (Q16.16)
//             and held, set when the new candidate was zero or overflowed
//             so the previous drive was kept.
//   cfg_*   : write port for the seven registers, index as listed in
//             pvc_pkg; write only while no sample is in flight.
// Sequencing: after the accept edge the sequencer works out the errors and
// wrap in S_ERR, then runs the one shared multiplier four times (trapezoid,
// then the p, i and d products), adds the terms, and loads the output
// register in S_OUT. ready rises again only once that load is done, so a
// new sample is taken only after the last one's drive word is loaded.
// Stall: the output register holds its word while result.ready is low; the
// next sample is still taken and worked out, and it waits in the final
// step until the output register frees up.
// Reset: integral, last error and drive clear; registers reload defaults.
`include "assert_macros.svh"

module pid_position_velocity_controller (
  input  logic                       clk,
  input  logic                       rst,
  pvc_in_if.sink                     sample,
  pvc_out_if.source                  result,
  input  logic                       cfg_we,
  input  logic [pvc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [pvc_pkg::REG_W-1:0]  cfg_data
);
  import pvc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ERR, S_TRAP, S_INT, S_MUL_I, S_MUL_D, S_SUM, S_OUT
  } state_t;

  state_t state;
  cfg_t   cfg;

  // captured sample word
  logic signed [31:0] ref_pos, ref_vel, meas_pos, meas_vel;

  // per-sample working registers
  logic signed [31:0]      pos_error, vel_error;
  logic signed [ACC_W-1:0] acc;

  // state that carries from one sample to the next
  logic signed [31:0] last_pos_error, error_integral, drive_reg;
  logic               held;
  logic               out_valid;

  mul_op_t                     sel;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]    prod;

  pvc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Error stage: exact 34-bit differences, single wrap by 2*pi, saturate.
  logic signed [33:0] pos_diff, vel_diff, pos_wrap;
  assign pos_diff = {{2{ref_pos[31]}}, ref_pos} - {{2{meas_pos[31]}}, meas_pos};
  assign vel_diff = {{2{ref_vel[31]}}, ref_vel} - {{2{meas_vel[31]}}, meas_vel};

  always_comb begin
    pos_wrap = pos_diff;
    if (cfg.angular_mode) begin
      priority if (pos_diff > Q_PI) begin
        pos_wrap = pos_diff - Q_TWO_PI;
      end else if (pos_diff < -Q_PI) begin
        pos_wrap = pos_diff + Q_TWO_PI;
      end
    end
  end

  // Trapezoid operand: this error plus the last one, 33 bits exact.
  logic signed [32:0] err_sum;
  assign err_sum = {pos_error[31], pos_error} + {last_pos_error[31], last_pos_error};

  // Pick multiplier operands by step; the product lands in the next cycle.
  always_comb begin
    unique case (state)
      S_INT:   sel = OP_GAIN_P;
      S_MUL_I: sel = OP_GAIN_I;
      S_MUL_D: sel = OP_GAIN_D;
      default: sel = OP_TRAP;
    endcase
  end

  pvc_opsel u_opsel (
    .sel       (sel),
    .err_sum   (err_sum),
    .pos_error (pos_error),
    .integral  (error_integral),
    .vel_error (vel_error),
    .cfg       (cfg),
    .a         (mul_a),
    .b         (mul_b)
  );

  pvc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Floor shifts of the product: /2^17 for the trapezoid, /2^16 for gains.
  logic signed [ACC_W-1:0] trap_term, gain_term;
  assign trap_term = {{(ACC_W-PROD_W+17){prod[PROD_W-1]}}, prod[PROD_W-1:17]};
  assign gain_term = {{(ACC_W-PROD_W+16){prod[PROD_W-1]}}, prod[PROD_W-1:16]};

  logic signed [ACC_W-1:0] integral_sum;
  assign integral_sum = {{(ACC_W-32){error_integral[31]}}, error_integral} + trap_term;

  // Final step: hold on zero or overflow, then clamp the drive register.
  logic               cand_held;
  logic signed [31:0] drive_pick, drive_clamped;
  logic signed [31:0] lim_pos, lim_neg;
  logic               out_free;
  logic               out_load;

  assign cand_held = (acc == '0) || !fits32(acc);
  assign drive_pick = cand_held ? drive_reg : acc[31:0];
  assign lim_pos = {1'b0, cfg.drive_limit};
  assign lim_neg = 32'sd0 - lim_pos;
  assign out_free = !out_valid || result.ready;
  assign out_load = (state == S_OUT) && out_free;

  always_comb begin
    drive_clamped = drive_pick;
    if (cfg.clamp_enable) begin
      priority if (drive_pick > lim_pos) begin
        drive_clamped = lim_pos;
      end else if (drive_pick < lim_neg) begin
        drive_clamped = lim_neg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      last_pos_error <= '0;
      error_integral <= '0;
      drive_reg      <= '0;
      held           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // load a finished word, else drop the output word once it is taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            ref_pos  <= sample.ref_position;
            ref_vel  <= sample.ref_velocity;
            meas_pos <= sample.meas_position;
            meas_vel <= sample.meas_velocity;
            state    <= S_ERR;
          end
        end
        S_ERR: begin
          pos_error <= sat32({{(ACC_W-34){pos_wrap[33]}}, pos_wrap});
          vel_error <= sat32({{(ACC_W-34){vel_diff[33]}}, vel_diff});
          state     <= S_TRAP;
        end
        S_TRAP: begin
          state <= S_INT;
        end
        S_INT: begin
          error_integral <= sat32(integral_sum);
          last_pos_error <= pos_error;
          state          <= S_MUL_I;
        end
        S_MUL_I: begin
          acc   <= gain_term;
          state <= S_MUL_D;
        end
        S_MUL_D: begin
          acc   <= acc + gain_term;
          state <= S_SUM;
        end
        S_SUM: begin
          acc   <= acc + gain_term;
          state <= S_OUT;
        end
        S_OUT: begin
          // hold here while the previous word still waits
          if (out_free) begin
            drive_reg <= drive_clamped;
            held      <= cand_held;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sample.ready = (state == S_IDLE);
  assign result.valid = out_valid;
  assign result.drive = drive_reg;
  assign result.held  = held;

  // Checks on the sequencer and the clamp.
  logic in_take, drive_in_limit;
  assign in_take = sample.valid && sample.ready;
  assign drive_in_limit = (drive_reg <= lim_pos) && (drive_reg >= lim_neg);

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_take, state == S_ERR)
  `ASSERT_NEXT(a_out_loaded, clk, rst, (state == S_OUT) && out_free, out_valid)
  `ASSERT_IMPLIES(a_drive_clamped, clk, rst, out_valid && cfg.clamp_enable, drive_in_limit)
endmodule

// ----- design/pvc_cfg.sv -----
// Configuration register file of the controller: decode writes by index.
// Depends on pvc_pkg.
module pvc_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pvc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [pvc_pkg::REG_W-1:0]   cfg_data,
  output pvc_pkg::cfg_t               cfg
);
  import pvc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p        <= '0;
      cfg.gain_i        <= '0;
      cfg.gain_d        <= '0;
      cfg.sample_period <= SAMPLE_PERIOD_RST;
      cfg.drive_limit   <= DRIVE_LIMIT_RST;
      cfg.angular_mode  <= 1'b0;
      cfg.clamp_enable  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:        cfg.gain_p        <= cfg_data;
        REG_GAIN_I:        cfg.gain_i        <= cfg_data;
        REG_GAIN_D:        cfg.gain_d        <= cfg_data;
        REG_SAMPLE_PERIOD: cfg.sample_period <= cfg_data;
        REG_DRIVE_LIMIT:   cfg.drive_limit   <= cfg_data;
        REG_ANGULAR_MODE:  cfg.angular_mode  <= cfg_data[0];
        REG_CLAMP_ENABLE:  cfg.clamp_enable  <= cfg_data[0];
        default: ;  // drop writes past the register list
      endcase
    end
  end
endmodule

// ----- design/pvc_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on pvc_pkg.
module pvc_mul (
  input  logic                               clk,
  input  logic signed [pvc_pkg::MUL_A_W-1:0] a,
  input  logic signed [pvc_pkg::MUL_B_W-1:0] b,
  output logic signed [pvc_pkg::PROD_W-1:0]  p
);
  import pvc_pkg::*;

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end
endmodule

// ----- design/pvc_top_note.sv -----
// Operand select of the shared multiplier: picks and sign-extends the operand pair.
// Depends on pvc_pkg.
module pvc_opsel (
  input  pvc_pkg::mul_op_t                   sel,
  input  logic signed [32:0]                 err_sum,
  input  logic signed [31:0]                 pos_error,
  input  logic signed [31:0]                 integral,
  input  logic signed [31:0]                 vel_error,
  input  pvc_pkg::cfg_t                      cfg,
  output logic signed [pvc_pkg::MUL_A_W-1:0] a,
  output logic signed [pvc_pkg::MUL_B_W-1:0] b
);
  import pvc_pkg::*;

  // Pair the error sum with the sample period, or an error with its gain.
  always_comb begin
    unique case (sel)
      OP_TRAP: begin
        a = err_sum;
        b = {1'b0, cfg.sample_period};
      end
      OP_GAIN_P: begin
        a = {pos_error[31], pos_error};
        b = {1'b0, cfg.gain_p};
      end
      OP_GAIN_I: begin
        a = {integral[31], integral};
        b = {1'b0, cfg.gain_i};
      end
      OP_GAIN_D: begin
        a = {vel_error[31], vel_error};
        b = {1'b0, cfg.gain_d};
      end
    endcase
  end
endmodule

// ----- sim/pvc_drive_checker.sv -----
// Checker for the position/velocity controller: snoops the config port and
// both channels, predicts each drive word and compares it as it leaves.
// Depends on pvc_pkg and the channel interfaces in pvc_if.
module pvc_drive_checker (
  input  logic                      clk,
  input  logic                      rst,
  pvc_in_if                         sample,
  pvc_out_if                        result,
  input  logic                      cfg_we,
  input  logic [pvc_pkg::IDX_W-1:0] cfg_index,
  input  logic [pvc_pkg::REG_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import pvc_pkg::*;

  localparam longint PI_FIX     = 205887;
  localparam longint TWO_PI_FIX = 411775;
  localparam longint I32_HI     = 64'sd2147483647;
  localparam longint I32_LO     = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               held;
  } drive_word_t;

  cfg_t        cfg;
  longint      prev_err;
  longint      integral;
  longint      drive_state;
  int          errors;
  drive_word_t drive_expected_q[$];

  function automatic longint clip32(input longint v);
    if (v > I32_HI) return I32_HI;
    if (v < I32_LO) return I32_LO;
    return v;
  endfunction

  // Advance the controller state by one sample and return the drive word.
  function automatic drive_word_t predict_drive(input logic signed [31:0] rp,
                                                input logic signed [31:0] rv,
                                                input logic signed [31:0] mp,
                                                input logic signed [31:0] mv);
    longint      pos_err;
    longint      vel_err;
    longint      trap;
    longint      cand;
    longint      lim;
    drive_word_t w;
    pos_err = longint'(rp) - longint'(mp);
    vel_err = clip32(longint'(rv) - longint'(mv));
    if (cfg.angular_mode) begin
      if (pos_err > PI_FIX) begin
        pos_err = pos_err - TWO_PI_FIX;
      end else if (pos_err < -PI_FIX) begin
        pos_err = pos_err + TWO_PI_FIX;
      end
    end
    pos_err  = clip32(pos_err);
    trap     = ((pos_err + prev_err) * longint'(cfg.sample_period)) >>> 17;
    integral = clip32(integral + trap);
    prev_err = pos_err;
    cand = ((longint'(cfg.gain_p) * pos_err) >>> 16)
         + ((longint'(cfg.gain_i) * integral) >>> 16)
         + ((longint'(cfg.gain_d) * vel_err) >>> 16);
    w.held = (cand == 0) || (cand > I32_HI) || (cand < I32_LO);
    if (!w.held) drive_state = cand;
    if (cfg.clamp_enable) begin
      lim = longint'(cfg.drive_limit);
      if (drive_state > lim) begin
        drive_state = lim;
      end else if (drive_state < -lim) begin
        drive_state = -lim;
      end
    end
    w.drive = drive_state[31:0];
    return w;
  endfunction

  always @(posedge clk) begin
    drive_word_t want;
    if (rst) begin
      cfg.gain_p        = '0;
      cfg.gain_i        = '0;
      cfg.gain_d        = '0;
      cfg.sample_period = SAMPLE_PERIOD_RST;
      cfg.drive_limit   = DRIVE_LIMIT_RST;
      cfg.angular_mode  = 1'b0;
      cfg.clamp_enable  = 1'b1;
      prev_err    = 0;
      integral    = 0;
      drive_state = 0;
      drive_expected_q.delete();
    end else begin
      // Check leaving words first: a word never stems from a same-edge sample.
      if (result.valid && result.ready) begin
        if (drive_expected_q.size() == 0) begin
          $display("%0t unexpected drive word: expected none, got drive %0d held %0b",
                   $time, result.drive, result.held);
          errors++;
        end else begin
          want = drive_expected_q.pop_front();
          if (result.drive !== want.drive) begin
            $display("%0t drive mismatch: expected %0d, got %0d",
                     $time, want.drive, result.drive);
            errors++;
          end
          if (result.held !== want.held) begin
            $display("%0t held mismatch: expected %0b, got %0b",
                     $time, want.held, result.held);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_P:        cfg.gain_p        = cfg_data;
          REG_GAIN_I:        cfg.gain_i        = cfg_data;
          REG_GAIN_D:        cfg.gain_d        = cfg_data;
          REG_SAMPLE_PERIOD: cfg.sample_period = cfg_data;
          REG_DRIVE_LIMIT:   cfg.drive_limit   = cfg_data;
          REG_ANGULAR_MODE:  cfg.angular_mode  = cfg_data[0];
          REG_CLAMP_ENABLE:  cfg.clamp_enable  = cfg_data[0];
          default: ;
        endcase
      end
      if (sample.valid && sample.ready) begin
        drive_expected_q.push_back(predict_drive(sample.ref_position, sample.ref_velocity,
                                                 sample.meas_position, sample.meas_velocity));
      end
    end
    fail_count  <= errors;
    outstanding <= drive_expected_q.size();
  end

endmodule

// ----- sim/tb_pid_position_velocity_controller.sv -----
// Top of the controller testbench: clock, reset, config writes, sample and
// result handshakes, verdict. Depends on pvc_pkg, pvc_if and pvc_drive_checker.
module tb_pid_position_velocity_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import pvc_pkg::*;

  // Index past the register list; the block must ignore writes to it.
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

  localparam logic [31:0] FIX_MAX = 32'h7fff_ffff;
  localparam logic [31:0] FIX_MIN = 32'h8000_0000;
  localparam logic [31:0] FIX_ONE = 32'h0001_0000;
  localparam logic [31:0] PI_FIX  = 32'd205887;

  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 103;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;
  int               fail_count;
  int               outstanding;
  // Random gaps on both channels are allowed only while this is set.
  bit               idle_on;

  pvc_in_if  sample_ch ();
  pvc_out_if result_ch ();

  pid_position_velocity_controller dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pvc_drive_checker drive_checker (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample_ch),
    .result      (result_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Write all seven registers back to back, then poke the spare index.
  // Lower the write enable only once, after the last write.
  task automatic apply_config(input cfg_t c);
    logic [REG_W-1:0] junk;
    junk = REG_W'($urandom());
    cfg_we <= 1'b1;
    cfg_index <= REG_GAIN_P;        cfg_data <= c.gain_p;        @(posedge clk);
    cfg_index <= REG_GAIN_I;        cfg_data <= c.gain_i;        @(posedge clk);
    cfg_index <= REG_GAIN_D;        cfg_data <= c.gain_d;        @(posedge clk);
    cfg_index <= REG_SAMPLE_PERIOD; cfg_data <= c.sample_period; @(posedge clk);
    cfg_index <= REG_DRIVE_LIMIT;   cfg_data <= c.drive_limit;   @(posedge clk);
    cfg_index <= REG_ANGULAR_MODE;  cfg_data <= {30'd0, c.angular_mode};  @(posedge clk);
    cfg_index <= REG_CLAMP_ENABLE;  cfg_data <= {30'd0, c.clamp_enable};  @(posedge clk);
    cfg_index <= REG_SPARE;         cfg_data <= junk;            @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one sample word and hold it until the block takes it. Called and
  // returning at a rising edge; valid stays high when no gap follows.
  task automatic send_sample(input logic [31:0] rp, input logic [31:0] rv,
                             input logic [31:0] mp, input logic [31:0] mv);
    int gap;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 13);
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.ref_position  <= rp;
    sample_ch.ref_velocity  <= rv;
    sample_ch.meas_position <= mp;
    sample_ch.meas_velocity <= mv;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  // Reference or velocity level: near zero half the time, else anywhere or at a rail.
  function automatic logic [31:0] pick_level();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom();
      2:       return FIX_MAX;
      3:       return FIX_MIN;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  // Error between reference and measurement: zero, small, around +/-pi or wild.
  function automatic logic [31:0] pick_offset();
    logic [31:0] near_pi;
    near_pi = PI_FIX + $urandom_range(0, 4) - 32'd2;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom();
      2:       return near_pi;
      3:       return -near_pi;
      default: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return {REG_W{1'b1}};
      2:       return REG_W'($urandom());
      default: return REG_W'($urandom_range(0, 32'h0002_0000));
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_period();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return {REG_W{1'b1}};
      2:       return REG_W'($urandom());
      default: return REG_W'($urandom_range(1, 2000));
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return {REG_W{1'b1}};
      2:       return REG_W'($urandom());
      default: return REG_W'($urandom_range(0, 32'h0010_0000));
    endcase
  endfunction

  task automatic send_random();
    logic [31:0] rp;
    logic [31:0] rv;
    rp = pick_level();
    rv = pick_level();
    send_sample(rp, rv, rp - pick_offset(), rv - pick_offset());
  endtask

  // Drop valid, hold until every predicted word has left, then let the
  // pipeline settle before anyone touches the registers.
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);
  endtask

  // Result side: stall in bursts while idling is on, otherwise take every word.
  initial begin
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  initial begin
    cfg_t c;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    sample_ch.valid         <= 1'b0;
    sample_ch.ref_position  <= '0;
    sample_ch.ref_velocity  <= '0;
    sample_ch.meas_position <= '0;
    sample_ch.meas_velocity <= '0;
    idle_on = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset values: all gains zero, so every candidate is zero and held.
    send_sample('0, '0, '0, '0);
    send_sample(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX);
    send_sample(FIX_MIN, FIX_MAX, FIX_MAX, FIX_MIN);
    wait_drained();

    // Angular wrap: just past +/-pi, exactly +/-pi, and errors so large that
    // one wrap still leaves them saturated. Then saturating velocity errors.
    c = '{gain_p: 31'd65536, gain_i: 31'd32768, gain_d: 31'd16384,
          sample_period: SAMPLE_PERIOD_RST, drive_limit: DRIVE_LIMIT_RST,
          angular_mode: 1'b1, clamp_enable: 1'b1};
    apply_config(c);
    send_sample(PI_FIX + 1, '0, '0, '0);
    send_sample('0, '0, PI_FIX + 1, '0);
    send_sample(PI_FIX, '0, '0, '0);
    send_sample('0, '0, PI_FIX, '0);
    send_sample(FIX_MAX, '0, FIX_MIN, '0);
    send_sample(FIX_MIN, '0, FIX_MAX, '0);
    send_sample('0, FIX_MAX, '0, FIX_MIN);
    send_sample('0, FIX_MIN, '0, FIX_MAX);
    wait_drained();

    // Largest proportional gain, no clamp: a drive at the rail, overflowing
    // candidates that keep it, and a zero candidate. The longest sample
    // period drives the integral into saturation.
    c = '{gain_p: {REG_W{1'b1}}, gain_i: '0, gain_d: '0,
          sample_period: {REG_W{1'b1}}, drive_limit: '0,
          angular_mode: 1'b0, clamp_enable: 1'b0};
    apply_config(c);
    send_sample(32'd1, '0, '0, '0);
    send_sample(FIX_ONE, '0, '0, '0);
    send_sample(FIX_ONE << 1, '0, '0, '0);
    send_sample(FIX_MIN, '0, '0, '0);
    send_sample('0, '0, '0, '0);
    wait_drained();

    // Clamp: a held step still pulls the kept drive into the new limit,
    // then both rails of the limit and a value inside it.
    c = '{gain_p: 31'd65536, gain_i: '0, gain_d: '0,
          sample_period: '0, drive_limit: 31'd1000,
          angular_mode: 1'b0, clamp_enable: 1'b1};
    apply_config(c);
    send_sample('0, '0, '0, '0);
    send_sample(32'h0100_0000, '0, '0, '0);
    send_sample('0, '0, 32'h0100_0000, '0);
    send_sample(32'd5, '0, '0, '0);
    wait_drained();

    // Random phases, each under a fresh setting; the last two run flat out.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_on = (p < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      c.gain_p        = pick_gain();
      c.gain_i        = pick_gain();
      c.gain_d        = pick_gain();
      c.sample_period = pick_period();
      c.drive_limit   = pick_limit();
      c.angular_mode  = 1'($urandom_range(0, 1));
      c.clamp_enable  = 1'($urandom_range(0, 1));
      apply_config(c);
      repeat (PHASE_ITEMS) send_random();
      wait_drained();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
